@@ sv/otc_pkg.sv @@
`timescale 1ns / 1ps
// package for the oblique tree classifier
// shared constants, command codes, fsm states and controller/datapath structs
package otc_pkg;

    localparam int MaxNodes    = 256;
    localparam int MaxRows     = 1024;
    localparam int MaxFeatures = 64;
    localparam int MaxDepth    = 64;

    localparam int NodeW  = $clog2(MaxNodes);
    localparam int RowW   = $clog2(MaxRows);
    localparam int FeatW  = $clog2(MaxFeatures);
    localparam int RcntW  = RowW + 1;
    localparam int BlkW   = NodeW + 1;
    localparam int DepthW = $clog2(MaxDepth + 1);

    typedef enum logic [1:0] {
        CMD_WR_NODE = 2'd0,
        CMD_WR_ROW  = 2'd1,
        CMD_WR_FEAT = 2'd2,
        CMD_CLASSIFY = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NODE_RD,
        ST_NODE_CHK,
        ST_ORD,
        ST_SEEK,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_DECIDE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic node_rd;
        logic ord_clr;
        logic ord_step;
        logic seek_clr;
        logic seek_step;
        logic scan_start;
        logic scan_step;
        logic acc_clr;
        logic take_branch;
        logic root;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_leaf;
        logic ord_done;
        logic seek_done;
        logic blk_empty;
        logic scan_done;
        logic acc_busy;
    } ctl_sts_t;

endpackage

@@ sv/otc_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine of the oblique tree classifier
// depends on otc_pkg
module otc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  otc_pkg::ctl_sts_t sts,
    input  logic              out_free,
    output otc_pkg::ctl_cmd_t cmd,
    output logic              busy,
    output logic              out_load,
    output logic              err
);

    otc_pkg::state_t state_reg, state_next;
    logic [otc_pkg::DepthW-1:0] steps_reg, steps_next;
    logic depth_hit;

    assign depth_hit = steps_reg == otc_pkg::DepthW'(otc_pkg::MaxDepth);
    // a leaf reached on the last allowed step is not an error
    assign err = depth_hit && !sts.is_leaf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= otc_pkg::ST_IDLE;
            steps_reg <= '0;
        end else begin
            state_reg <= state_next;
            steps_reg <= steps_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        steps_next = steps_reg;
        unique case (state_reg)
            otc_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = otc_pkg::ST_NODE_RD;
                    steps_next = '0;
                end
            end
            otc_pkg::ST_NODE_RD: state_next = otc_pkg::ST_NODE_CHK;
            otc_pkg::ST_NODE_CHK: begin
                if (sts.is_leaf || depth_hit) state_next = otc_pkg::ST_OUT;
                else state_next = otc_pkg::ST_ORD;
            end
            otc_pkg::ST_ORD: if (sts.ord_done) state_next = otc_pkg::ST_SEEK;
            otc_pkg::ST_SEEK: begin
                if (sts.seek_done) begin
                    if (sts.blk_empty) state_next = otc_pkg::ST_DECIDE;
                    else state_next = otc_pkg::ST_SCAN;
                end
            end
            otc_pkg::ST_SCAN: if (sts.scan_done) state_next = otc_pkg::ST_SCAN_DRAIN;
            otc_pkg::ST_SCAN_DRAIN: if (!sts.acc_busy) state_next = otc_pkg::ST_DECIDE;
            otc_pkg::ST_DECIDE: begin
                state_next = otc_pkg::ST_NODE_RD;
                steps_next = steps_reg + 1'b1;
            end
            otc_pkg::ST_OUT: if (out_free) state_next = otc_pkg::ST_IDLE;
            default: state_next = otc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        busy = state_reg != otc_pkg::ST_IDLE;
        out_load = 1'b0;
        unique case (state_reg)
            otc_pkg::ST_IDLE: cmd.root = start;
            otc_pkg::ST_NODE_RD: cmd.node_rd = 1'b1;
            otc_pkg::ST_NODE_CHK: begin
                cmd.ord_clr = 1'b1;
                cmd.seek_clr = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            otc_pkg::ST_ORD: cmd.ord_step = 1'b1;
            otc_pkg::ST_SEEK: begin
                cmd.seek_step = 1'b1;
                cmd.scan_start = sts.seek_done;
            end
            otc_pkg::ST_SCAN: cmd.scan_step = 1'b1;
            otc_pkg::ST_SCAN_DRAIN: ;
            otc_pkg::ST_DECIDE: cmd.take_branch = 1'b1;
            otc_pkg::ST_OUT: out_load = out_free;
            default: ;
        endcase
    end

endmodule

@@ sv/otc_datapath.sv @@
`timescale 1ns / 1ps
// datapath of the oblique tree classifier: tables, block search, mac, node walk
// depends on otc_pkg
module otc_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [1:0]               wr_cmd,
    input  logic [9:0]               wr_addr,
    input  logic [7:0]               child_link,
    input  logic [7:0]               cut_group,
    input  logic signed [63:0]       cut_threshold,
    input  logic [7:0]               label_code,
    input  logic [6:0]               row_feature,
    input  logic [7:0]               row_group,
    input  logic signed [31:0]       row_weight,
    input  logic signed [31:0]       feature_value,
    input  logic [10:0]              rows_used,
    input  otc_pkg::ctl_cmd_t        cmd,
    output otc_pkg::ctl_sts_t        sts,
    output logic [7:0]               node_index,
    output logic [7:0]               node_label
);

    localparam int NW = otc_pkg::NodeW;
    localparam int RW = otc_pkg::RowW;
    localparam int CW = otc_pkg::RcntW;
    localparam int FW = otc_pkg::FeatW;
    localparam int BW = otc_pkg::BlkW;

    logic [7:0]         n_child_mem [otc_pkg::MaxNodes];
    logic [7:0]         n_group_mem [otc_pkg::MaxNodes];
    logic signed [63:0] n_thr_mem   [otc_pkg::MaxNodes];
    logic [7:0]         n_label_mem [otc_pkg::MaxNodes];
    logic [6:0]         r_feat_mem  [otc_pkg::MaxRows];
    logic [7:0]         r_group_mem [otc_pkg::MaxRows];
    logic signed [31:0] r_wt_mem    [otc_pkg::MaxRows];
    logic signed [31:0] feat_mem    [otc_pkg::MaxFeatures];

    logic [NW-1:0] node_reg;
    logic [7:0] child_reg, group_reg, label_reg;
    logic signed [63:0] thr_reg;

    // ordinal search reads group of node k
    logic [NW:0] ord_k_reg;
    logic [BW-1:0] zeros_reg;
    logic [7:0] ord_grp_reg;
    logic ord_vld_reg;

    // block seek over rows
    logic [CW-1:0] seek_t_reg;
    logic [BW-1:0] seps_reg;
    logic [CW-1:0] lo_reg;
    logic seek_done_reg, blk_empty_reg;
    logic [6:0] seek_feat_reg;
    logic seek_vld_reg;
    logic [CW-1:0] seek_rd_t_reg;

    // scan
    logic [CW-1:0] scan_t_reg;
    logic scan_done_reg;
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [6:0] s1_feat_reg;
    logic [7:0] s1_grp_reg;
    logic signed [31:0] s1_wt_reg;
    logic signed [31:0] s2_wt_reg, s2_fv_reg;
    logic s2_use_reg;
    logic signed [63:0] s3_prod_reg;
    logic s3_use_reg;
    logic signed [63:0] acc_reg;

    logic [CW-1:0] n_rows;
    logic [BW-1:0] b_ord;
    logic [6:0] rd_feat;
    logic signed [64:0] sum_w;

    assign n_rows = (rows_used > CW'(otc_pkg::MaxRows)) ? CW'(otc_pkg::MaxRows) : rows_used;

    always_ff @(posedge aclk) begin
        if (wr_en && wr_cmd == otc_pkg::CMD_WR_NODE && wr_addr < 10'(otc_pkg::MaxNodes)) begin
            n_child_mem[wr_addr[NW-1:0]] <= child_link;
            n_group_mem[wr_addr[NW-1:0]] <= cut_group;
            n_thr_mem[wr_addr[NW-1:0]]   <= cut_threshold;
            n_label_mem[wr_addr[NW-1:0]] <= label_code;
        end
        if (wr_en && wr_cmd == otc_pkg::CMD_WR_ROW) begin
            r_feat_mem[wr_addr[RW-1:0]]  <= row_feature;
            r_group_mem[wr_addr[RW-1:0]] <= row_group;
            r_wt_mem[wr_addr[RW-1:0]]    <= row_weight;
        end
        if (wr_en && wr_cmd == otc_pkg::CMD_WR_FEAT && wr_addr < 10'(otc_pkg::MaxFeatures))
            feat_mem[wr_addr[FW-1:0]] <= feature_value;
    end

    // node entry read
    always_ff @(posedge aclk) begin
        if (cmd.node_rd) begin
            child_reg <= n_child_mem[node_reg];
            group_reg <= n_group_mem[node_reg];
            thr_reg   <= n_thr_mem[node_reg];
            label_reg <= n_label_mem[node_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) node_reg <= '0;
        else if (cmd.root) node_reg <= '0;
        else if (cmd.take_branch) begin
            if ($signed(acc_reg) < thr_reg) node_reg <= NW'(child_reg - 8'd1);
            else node_reg <= NW'(child_reg);
        end
    end

    // ordinal: count zero groups among nodes 0..node, one node a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ord_k_reg <= '0;
            ord_vld_reg <= 1'b0;
            zeros_reg <= '0;
        end else if (cmd.ord_clr) begin
            ord_k_reg <= '0;
            ord_vld_reg <= 1'b0;
            zeros_reg <= '0;
        end else if (cmd.ord_step) begin
            if (ord_k_reg <= {1'b0, node_reg}) begin
                ord_grp_reg <= n_group_mem[ord_k_reg[NW-1:0]];
                ord_k_reg <= ord_k_reg + 1'b1;
            end
            ord_vld_reg <= ord_k_reg <= {1'b0, node_reg};
            if (ord_vld_reg && ord_grp_reg == 8'd0) zeros_reg <= zeros_reg + 1'b1;
        end
    end
    assign sts.ord_done = cmd.ord_step && !ord_vld_reg && ord_k_reg > {1'b0, node_reg};
    assign b_ord = BW'(node_reg) - zeros_reg;

    // seek: walk rows to find start of block b and its closing separator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seek_t_reg <= '0;
            seps_reg <= '0;
            lo_reg <= '0;
            seek_done_reg <= 1'b0;
            blk_empty_reg <= 1'b0;
            seek_vld_reg <= 1'b0;
        end else if (cmd.seek_clr) begin
            seek_t_reg <= '0;
            seps_reg <= '0;
            lo_reg <= '0;
            seek_done_reg <= 1'b0;
            blk_empty_reg <= 1'b0;
            seek_vld_reg <= 1'b0;
        end else if (cmd.seek_step && !seek_done_reg) begin
            if (zeros_reg > BW'(node_reg)) begin
                seek_done_reg <= 1'b1;
                blk_empty_reg <= 1'b1;
            end else begin
                if (seek_t_reg < n_rows) begin
                    seek_feat_reg <= r_feat_mem[seek_t_reg[RW-1:0]];
                    seek_rd_t_reg <= seek_t_reg;
                    seek_t_reg <= seek_t_reg + 1'b1;
                    seek_vld_reg <= 1'b1;
                end else begin
                    seek_vld_reg <= 1'b0;
                end
                if (seek_vld_reg && seek_feat_reg == 7'd0 &&
                    seps_reg < BW'(otc_pkg::MaxNodes)) begin
                    seps_reg <= seps_reg + 1'b1;
                    if (seps_reg == b_ord) begin
                        seek_done_reg <= 1'b1;
                        blk_empty_reg <= 1'b0;
                    end else begin
                        lo_reg <= seek_rd_t_reg + 1'b1;
                    end
                end else if (!seek_vld_reg && seek_t_reg >= n_rows) begin
                    seek_done_reg <= 1'b1;
                    blk_empty_reg <= 1'b1;
                end
            end
        end
    end
    assign sts.seek_done = seek_done_reg;
    assign sts.blk_empty = blk_empty_reg;

    // scan rows lo..separator-1 through a three-stage mac
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_t_reg <= '0;
            scan_done_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            if (cmd.scan_start) begin
                scan_t_reg <= lo_reg;
                scan_done_reg <= 1'b0;
            end
            s1_vld_reg <= 1'b0;
            if (cmd.scan_step && !scan_done_reg) begin
                if (scan_t_reg == seek_rd_t_reg) scan_done_reg <= 1'b1;
                else begin
                    s1_feat_reg <= r_feat_mem[scan_t_reg[RW-1:0]];
                    s1_grp_reg <= r_group_mem[scan_t_reg[RW-1:0]];
                    s1_wt_reg <= r_wt_mem[scan_t_reg[RW-1:0]];
                    s1_vld_reg <= 1'b1;
                    scan_t_reg <= scan_t_reg + 1'b1;
                end
            end
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    assign rd_feat = s1_feat_reg - 7'd1;
    always_ff @(posedge aclk) begin
        s2_use_reg <= s1_grp_reg == group_reg && s1_feat_reg != 7'd0 &&
                      s1_feat_reg <= 7'(otc_pkg::MaxFeatures);
        s2_fv_reg <= feat_mem[rd_feat[FW-1:0]];
        s2_wt_reg <= s1_wt_reg;
        s3_prod_reg <= s2_fv_reg * s2_wt_reg;
        s3_use_reg <= s2_use_reg;
    end

    assign sum_w = {acc_reg[63], acc_reg} + {s3_prod_reg[63], s3_prod_reg};
    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) acc_reg <= '0;
        else if (s3_vld_reg && s3_use_reg) begin
            if (sum_w[64] != sum_w[63])
                acc_reg <= sum_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
                acc_reg <= sum_w[63:0];
        end
    end

    assign sts.scan_done = scan_done_reg;
    assign sts.acc_busy = s1_vld_reg || s2_vld_reg || s3_vld_reg;
    assign sts.is_leaf = child_reg == 8'd0;
    assign node_index = 8'(node_reg);
    assign node_label = label_reg;

endmodule

@@ sv/oblique_tree_classifier.sv @@
`timescale 1ns / 1ps
// top level of the oblique tree classifier: controller, datapath, result register
// depends on otc_pkg, otc_ctrl, otc_datapath
//
// channel   dir  fields
// s_axis    in   tdata: command, address, child_link, cut_group, cut_threshold,
//                label_code, row_feature, row_group, row_weight, feature_value
// m_axis    out  tdata: leaf_index, leaf_label, walk_error
// cfg       in   projection_rows_used
//
// a classify visits each internal node in turn: per node an ordinal count over
// nodes 0..node_index, a block search over the row memory port, and the mac over
// the rows of the block; the row memory port sets the time spent per node.
// reset clears control state only; tables hold garbage until written.
// s_tready is low while a classify is in flight; a held result stalls the next
// classify at its output step.
module oblique_tree_classifier (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], address[11:2], child_link[19:12], cut_group[27:20],
    // cut_threshold[91:28], label_code[99:92], row_feature[106:100],
    // row_group[114:107], row_weight[146:115], feature_value[178:147]
    input  logic [183:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // leaf_index[7:0], leaf_label[15:8], walk_error[16]
    output logic [23:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [10:0]  cfg_wdata
);

    logic [10:0] rows_used_reg;
    logic busy, out_load, err, start, accept;
    otc_pkg::ctl_cmd_t cmd;
    otc_pkg::ctl_sts_t sts;
    logic [7:0] node_index, node_label;
    logic m_valid_reg;
    logic [16:0] m_data_reg;

    assign s_tready = !busy;
    assign accept = s_tvalid && s_tready;
    assign start = accept && s_tdata[1:0] == otc_pkg::CMD_CLASSIFY;

    always_ff @(posedge aclk) begin
        if (!aresetn) rows_used_reg <= '0;
        else if (cfg_we) rows_used_reg <= cfg_wdata;
    end

    otc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .sts      (sts),
        .out_free (!m_valid_reg || m_tready),
        .cmd      (cmd),
        .busy     (busy),
        .out_load (out_load),
        .err      (err)
    );

    otc_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wr_en         (accept),
        .wr_cmd        (s_tdata[1:0]),
        .wr_addr       (s_tdata[11:2]),
        .child_link    (s_tdata[19:12]),
        .cut_group     (s_tdata[27:20]),
        .cut_threshold (s_tdata[91:28]),
        .label_code    (s_tdata[99:92]),
        .row_feature   (s_tdata[106:100]),
        .row_group     (s_tdata[114:107]),
        .row_weight    (s_tdata[146:115]),
        .feature_value (s_tdata[178:147]),
        .rows_used     (rows_used_reg),
        .cmd           (cmd),
        .sts           (sts),
        .node_index    (node_index),
        .node_label    (node_label)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (out_load) m_valid_reg <= 1'b1;
        else if (m_tready) m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (out_load) m_data_reg <= {err, node_label, node_index};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {7'd0, m_data_reg};

endmodule
